// ===== src/elastic_collision_3d_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ELASTIC_COLLISION_3D_MACROS_SVH
`define ELASTIC_COLLISION_3D_MACROS_SVH

// same-cycle implication, checked while out of reset
`define EC3_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define EC3_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ec3_pkg.sv =====
package ec3_pkg;

	localparam int EC3_FRAC_BITS   = 16;
	localparam int EC3_VALUE_WIDTH = 32;

	// opcode of an input word
	localparam logic OPC_LOAD    = 1'b0;
	localparam logic OPC_RESOLVE = 1'b1;

	// body index of a result word
	localparam logic BODY_FIRST  = 1'b0;
	localparam logic BODY_SECOND = 1'b1;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} ec3_op_t;

	typedef struct packed {
		logic    start;
		ec3_op_t op;
	} ec3_req_t;

endpackage

// ===== src/ec3_sphere_if.sv =====
interface ec3_sphere_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [VALUE_WIDTH-1:0] pos_x;
	logic [VALUE_WIDTH-1:0] pos_y;
	logic [VALUE_WIDTH-1:0] pos_z;
	logic [VALUE_WIDTH-1:0] vel_u;
	logic [VALUE_WIDTH-1:0] vel_v;
	logic [VALUE_WIDTH-1:0] vel_w;
	logic [VALUE_WIDTH-1:0] body_mass;
	logic [VALUE_WIDTH-2:0] body_radius;

	modport source (
		output valid, opcode, pos_x, pos_y, pos_z, vel_u, vel_v, vel_w,
			body_mass, body_radius,
		input  ready
	);
	modport sink (
		input  valid, opcode, pos_x, pos_y, pos_z, vel_u, vel_v, vel_w,
			body_mass, body_radius,
		output ready
	);
endinterface

// ===== src/ec3_vel_if.sv =====
interface ec3_vel_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic                   which_body;
	logic [VALUE_WIDTH-1:0] new_u;
	logic [VALUE_WIDTH-1:0] new_v;
	logic [VALUE_WIDTH-1:0] new_w;
	logic                   collided;
	logic                   coincident;
	logic                   saturated;
	logic                   last_result;

	modport source (
		output valid, which_body, new_u, new_v, new_w, collided, coincident,
			saturated, last_result,
		input  ready
	);
	modport sink (
		input  valid, which_body, new_u, new_v, new_w, collided, coincident,
			saturated, last_result,
		output ready
	);
endinterface

// ===== src/ec3_unit.sv =====
module ec3_unit import ec3_pkg::*; #(
	parameter  int VALUE_WIDTH = EC3_VALUE_WIDTH,
	localparam int WW          = 4 * VALUE_WIDTH + 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ec3_req_t      req,
	input  logic [WW-1:0] opa,
	input  logic [WW-1:0] opb,
	output logic          done,
	output logic [WW-1:0] res
);
	localparam int CW = $clog2(VALUE_WIDTH + 2);

	logic          busy_q;
	logic          done_q;
	ec3_op_t       op_q;
	logic [WW-1:0] acc_q;
	logic [WW-1:0] a_q;
	logic [WW-1:0] b_q;
	logic [CW-1:0] cnt_q;

	logic          is_div;
	logic [WW-1:0] add_b;
	logic [WW:0]   sum;
	logic          finish;

	// one adder: acc + a for shift-add multiply, acc - b for restoring divide
	assign is_div = (op_q == OP_DIV);
	assign add_b  = is_div ? ~b_q : a_q;
	assign sum    = {1'b0, acc_q} + {1'b0, add_b} + {{WW{1'b0}}, is_div};
	assign finish = busy_q && (is_div ? (cnt_q == '0) : (b_q == '0));

	assign done = done_q;
	assign res  = is_div ? a_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= finish;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			cnt_q <= CW'(VALUE_WIDTH + 1);
			if (req.op == OP_DIV) begin
				acc_q <= opa;
				a_q   <= '0;
				b_q   <= opb << (VALUE_WIDTH + 1);
			end else begin
				acc_q <= '0;
				a_q   <= opa;
				b_q   <= opb;
			end
		end else if (busy_q) begin
			if (is_div) begin
				// quotient bit is the carry out of the trial subtract
				if (sum[WW])
					acc_q <= sum[WW-1:0];
				a_q <= {a_q[WW-2:0], sum[WW]};
				b_q <= b_q >> 1;
				if (cnt_q != '0)
					cnt_q <= cnt_q - 1'b1;
			end else if (b_q != '0) begin
				if (b_q[0])
					acc_q <= sum[WW-1:0];
				a_q <= a_q << 1;
				b_q <= b_q >> 1;
			end
		end
	end

endmodule

// ===== src/elastic_collision_3d.sv =====
// channel   | dir | handshake     | word
// ----------+-----+---------------+---------------------------------------------
// sphere    | in  | valid / ready | opcode, position, velocity, mass, radius
// velocity  | out | valid / ready | which body, new velocity, contact flags
//
// a load word (opcode 0) replaces the held sphere and leaves the sequencer idle; a resolve
// word keeps ready low until its second result word is loaded into the output register
// arst_n clears the sequencer, the output valid and the held sphere (mass one)
// a stalled velocity channel holds the pending word and stops the sequencer
`include "elastic_collision_3d_macros.svh"

module elastic_collision_3d import ec3_pkg::*; #(
	parameter int FRAC_BITS   = EC3_FRAC_BITS,
	parameter int VALUE_WIDTH = EC3_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	ec3_sphere_if.sink  sphere,
	ec3_vel_if.source   velocity
);
	localparam int W  = VALUE_WIDTH;
	localparam int WW = 4 * W + 4;
	localparam logic [1:0] AX_LAST = 2'd2;

	// one-hot sequencer
	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_DIFF  = 13'b0000000000010,
		ST_SQ    = 13'b0000000000100,
		ST_DOT   = 13'b0000000001000,
		ST_RR    = 13'b0000000010000,
		ST_CHK   = 13'b0000000100000,
		ST_DEN   = 13'b0000001000000,
		ST_TMUL  = 13'b0000010000000,
		ST_NMUL  = 13'b0000100000000,
		ST_DIV   = 13'b0001000000000,
		ST_FIN   = 13'b0010000000000,
		ST_EMIT0 = 13'b0100000000000,
		ST_EMIT1 = 13'b1000000000000
	} state_t;

	state_t       state_q;
	logic [1:0]   ax_q;
	logic         body_q;
	logic         pend_q;

	// held (first) sphere
	logic [W-1:0] hpos_q [3];
	logic [W-1:0] hvel_q [3];
	logic [W-1:0] hmass_q;
	logic [W-2:0] hrad_q;

	// second sphere of the current resolve
	logic [W-1:0] p2_q [3];
	logic [W-1:0] v2_q [3];
	logic [W-1:0] m2_q;
	logic [W-2:0] r2_q;

	// intermediate terms, sign in the top bit where signed
	logic [W:0]      d_q  [3];
	logic [W:0]      dv_q [3];
	logic [W-1:0]    rsum_q;
	logic [W:0]      msum_q;
	logic [2*W+1:0]  s_q;
	logic [2*W+2:0]  dot_q;
	logic [2*W-1:0]  rr_q;
	logic [3*W+2:0]  den_q;
	logic [3*W+1:0]  t_q;

	// resolved velocities
	logic [W-1:0] r1_q [3];
	logic [W-1:0] r2v_q [3];
	logic         sat1_q;
	logic         sat2_q;
	logic         coll_q;
	logic         coin_q;

	// output register
	logic         out_valid_q;
	logic         out_body_q;
	logic [W-1:0] out_u_q;
	logic [W-1:0] out_v_q;
	logic [W-1:0] out_w_q;
	logic         out_coll_q;
	logic         out_coin_q;
	logic         out_sat_q;
	logic         out_last_q;

	ec3_req_t      unit_req;
	logic [WW-1:0] unit_a;
	logic [WW-1:0] unit_b;
	logic          unit_done;
	logic [WW-1:0] unit_res;

	logic           accept;
	logic           slot_free;
	logic           out_load;
	logic           emit_second;
	logic           op_state;
	logic           hit;
	logic [W:0]     d_cur;
	logic [W:0]     dv_cur;
	logic [W:0]     d_mag;
	logic [W:0]     dv_mag;
	logic [2*W+2:0] dot_mag;
	logic [2*W+2:0] prod_ext;

	// impulse finish terms
	logic [W+1:0] q;
	logic         q_over;
	logic [W:0]   qc;
	logic         dneg;
	logic [W+1:0] delta;
	logic [W-1:0] vsel;
	logic [W+1:0] vext;
	logic [W+1:0] vsum;
	logic         clip_hi;
	logic         clip_lo;
	logic [W-1:0] vnew;

	assign accept      = sphere.valid && sphere.ready;
	assign sphere.ready = (state_q == ST_IDLE);
	assign slot_free   = !out_valid_q || velocity.ready;
	assign emit_second = (state_q == ST_EMIT1);
	assign out_load    = ((state_q == ST_EMIT0) || emit_second) && slot_free;

	assign velocity.valid       = out_valid_q;
	assign velocity.which_body  = out_body_q;
	assign velocity.new_u       = out_u_q;
	assign velocity.new_v       = out_v_q;
	assign velocity.new_w       = out_w_q;
	assign velocity.collided    = out_coll_q;
	assign velocity.coincident  = out_coin_q;
	assign velocity.saturated   = out_sat_q;
	assign velocity.last_result = out_last_q;

	// magnitudes of the current axis terms
	assign d_cur    = d_q[ax_q];
	assign dv_cur   = dv_q[ax_q];
	assign d_mag    = d_cur[W] ? (~d_cur + 1'b1) : d_cur;
	assign dv_mag   = dv_cur[W] ? (~dv_cur + 1'b1) : dv_cur;
	assign dot_mag  = dot_q[2*W+2] ? (~dot_q + 1'b1) : dot_q;
	assign prod_ext = {2'b00, unit_res[2*W:0]};

	// touching, not coincident, and a nonzero mass sum
	assign hit = (s_q <= {2'b00, rr_q}) && (s_q != '0) && (msum_q != '0);

	// shared unit: one request per arithmetic state
	assign op_state = (state_q == ST_SQ) || (state_q == ST_DOT) || (state_q == ST_RR) ||
		(state_q == ST_DEN) || (state_q == ST_TMUL) || (state_q == ST_NMUL) ||
		(state_q == ST_DIV);
	assign unit_req.start = op_state && !pend_q;
	assign unit_req.op    = (state_q == ST_DIV) ? OP_DIV : OP_MUL;

	always_comb begin
		unit_a = '0;
		unit_b = '0;
		unique case (state_q)
			ST_SQ: begin
				unit_a = WW'(d_mag);
				unit_b = WW'(d_mag);
			end
			ST_DOT: begin
				unit_a = WW'(d_mag);
				unit_b = WW'(dv_mag);
			end
			ST_RR: begin
				unit_a = WW'(rsum_q);
				unit_b = WW'(rsum_q);
			end
			ST_DEN: begin
				unit_a = WW'(s_q);
				unit_b = WW'(msum_q);
			end
			ST_TMUL: begin
				unit_a = WW'(dot_mag);
				unit_b = WW'(d_mag);
			end
			ST_NMUL: begin
				// first body takes the other body's mass, times two
				unit_a = WW'(t_q);
				unit_b = (body_q == BODY_FIRST) ? WW'({m2_q, 1'b0}) : WW'({hmass_q, 1'b0});
			end
			ST_DIV: begin
				// numerator is still in the unit accumulator
				unit_a = unit_res;
				unit_b = WW'(den_q);
			end
			default: begin
				unit_a = '0;
				unit_b = '0;
			end
		endcase
	end

	ec3_unit #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (unit_req),
		.opa    (unit_a),
		.opb    (unit_b),
		.done   (unit_done),
		.res    (unit_res)
	);

	// quotient capped at 2^W, signed, applied and clamped
	assign q       = unit_res[W+1:0];
	assign q_over  = q[W+1] || (q[W] && (q[W-1:0] != '0));
	assign qc      = q_over ? {1'b1, {W{1'b0}}} : q[W:0];
	assign dneg    = d_cur[W] ^ dot_q[2*W+2];
	assign delta   = dneg ? (~{1'b0, qc} + 1'b1) : {1'b0, qc};
	assign vsel    = (body_q == BODY_FIRST) ? hvel_q[ax_q] : v2_q[ax_q];
	assign vext    = {{2{vsel[W-1]}}, vsel};
	assign vsum    = (body_q == BODY_FIRST) ? (vext - delta) : (vext + delta);
	assign clip_hi = !vsum[W+1] && (vsum[W] || vsum[W-1]);
	assign clip_lo = vsum[W+1] && !(vsum[W] && vsum[W-1]);
	assign vnew    = clip_hi ? {1'b0, {(W-1){1'b1}}} :
		clip_lo ? {1'b1, {(W-1){1'b0}}} : vsum[W-1:0];

	// control and held sphere
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			body_q      <= BODY_FIRST;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hpos_q      <= '{default: '0};
			hvel_q      <= '{default: '0};
			hmass_q     <= W'(1) << FRAC_BITS;
			hrad_q      <= '0;
		end else begin
			if (unit_req.start)
				pend_q <= 1'b1;
			else if (unit_done)
				pend_q <= 1'b0;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (velocity.ready)
				out_valid_q <= 1'b0;

			if (accept && (sphere.opcode == OPC_LOAD)) begin
				hpos_q[0] <= sphere.pos_x;
				hpos_q[1] <= sphere.pos_y;
				hpos_q[2] <= sphere.pos_z;
				hvel_q[0] <= sphere.vel_u;
				hvel_q[1] <= sphere.vel_v;
				hvel_q[2] <= sphere.vel_w;
				hmass_q   <= sphere.body_mass;
				hrad_q    <= sphere.body_radius;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (sphere.opcode == OPC_RESOLVE)) begin
						ax_q    <= '0;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					if (ax_q == AX_LAST) begin
						ax_q    <= '0;
						state_q <= ST_SQ;
					end else begin
						ax_q <= ax_q + 1'b1;
					end
				end
				ST_SQ: begin
					if (unit_done)
						state_q <= ST_DOT;
				end
				ST_DOT: begin
					if (unit_done) begin
						if (ax_q == AX_LAST) begin
							ax_q    <= '0;
							state_q <= ST_RR;
						end else begin
							ax_q    <= ax_q + 1'b1;
							state_q <= ST_SQ;
						end
					end
				end
				ST_RR: begin
					if (unit_done)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					ax_q    <= '0;
					body_q  <= BODY_FIRST;
					state_q <= hit ? ST_DEN : ST_EMIT0;
				end
				ST_DEN: begin
					if (unit_done)
						state_q <= ST_TMUL;
				end
				ST_TMUL: begin
					if (unit_done) begin
						body_q  <= BODY_FIRST;
						state_q <= ST_NMUL;
					end
				end
				ST_NMUL: begin
					if (unit_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (unit_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (body_q == BODY_FIRST) begin
						body_q  <= BODY_SECOND;
						state_q <= ST_NMUL;
					end else if (ax_q == AX_LAST) begin
						state_q <= ST_EMIT0;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= ST_TMUL;
					end
				end
				ST_EMIT0: begin
					if (slot_free)
						state_q <= ST_EMIT1;
				end
				ST_EMIT1: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			p2_q[0] <= sphere.pos_x;
			p2_q[1] <= sphere.pos_y;
			p2_q[2] <= sphere.pos_z;
			v2_q[0] <= sphere.vel_u;
			v2_q[1] <= sphere.vel_v;
			v2_q[2] <= sphere.vel_w;
			m2_q    <= sphere.body_mass;
			r2_q    <= sphere.body_radius;
		end

		unique case (state_q)
			ST_IDLE: begin
				s_q   <= '0;
				dot_q <= '0;
			end
			ST_DIFF: begin
				// d = p1 - p2 and dv = v1 - v2, one bit wider
				d_q[ax_q]  <= {hpos_q[ax_q][W-1], hpos_q[ax_q]} - {p2_q[ax_q][W-1], p2_q[ax_q]};
				dv_q[ax_q] <= {hvel_q[ax_q][W-1], hvel_q[ax_q]} - {v2_q[ax_q][W-1], v2_q[ax_q]};
				rsum_q     <= {1'b0, hrad_q} + {1'b0, r2_q};
				msum_q     <= {1'b0, hmass_q} + {1'b0, m2_q};
			end
			ST_SQ: begin
				if (unit_done)
					s_q <= s_q + {1'b0, unit_res[2*W:0]};
			end
			ST_DOT: begin
				if (unit_done)
					dot_q <= (d_cur[W] ^ dv_cur[W]) ? (dot_q - prod_ext) : (dot_q + prod_ext);
			end
			ST_RR: begin
				if (unit_done)
					rr_q <= unit_res[2*W-1:0];
			end
			ST_CHK: begin
				coll_q <= (s_q <= {2'b00, rr_q});
				coin_q <= (s_q == '0);
				r1_q   <= hvel_q;
				r2v_q  <= v2_q;
				sat1_q <= 1'b0;
				sat2_q <= 1'b0;
			end
			ST_DEN: begin
				if (unit_done)
					den_q <= unit_res[3*W+2:0];
			end
			ST_TMUL: begin
				if (unit_done)
					t_q <= unit_res[3*W+1:0];
			end
			ST_FIN: begin
				if (body_q == BODY_FIRST) begin
					r1_q[ax_q] <= vnew;
					sat1_q     <= sat1_q || clip_hi || clip_lo;
				end else begin
					r2v_q[ax_q] <= vnew;
					sat2_q      <= sat2_q || clip_hi || clip_lo;
				end
			end
			ST_EMIT0, ST_EMIT1: begin
				if (out_load) begin
					out_body_q <= emit_second ? BODY_SECOND : BODY_FIRST;
					out_u_q    <= emit_second ? r2v_q[0] : r1_q[0];
					out_v_q    <= emit_second ? r2v_q[1] : r1_q[1];
					out_w_q    <= emit_second ? r2v_q[2] : r1_q[2];
					out_coll_q <= coll_q;
					out_coin_q <= coin_q;
					out_sat_q  <= emit_second ? sat2_q : sat1_q;
					out_last_q <= emit_second;
				end
			end
			default: ;
		endcase
	end

	// the shared unit never runs while a new word can be taken
	`EC3_ASSERT_IMPL(a_ready_unit_idle, clk, arst_n, sphere.ready, !pend_q, "ready with unit busy")
	// a unit completion always answers an issued request
	`EC3_ASSERT_IMPL(a_done_pending, clk, arst_n, unit_done, pend_q, "unit done without request")
	// a resolve word starts the difference pass
	`EC3_ASSERT_NEXT(a_resolve_start, clk, arst_n, accept && (sphere.opcode == OPC_RESOLVE), state_q == ST_DIFF, "resolve did not start")

endmodule
